// ===== rtl/stt_pkg.sv =====
// Shared types, token codes and keyword tables for the source text tokenizer.
`timescale 1ns / 1ps

package stt_pkg;

  localparam int unsigned POSITION_BITS_DEF = 16;
  localparam int unsigned KEYWORD_CHARS_DEF = 5;

  // Width of every position, length and line field on the result channel.
  localparam int unsigned FIELD_W = 16;
  localparam int unsigned LINE_W  = 16;

  // Token kinds.
  localparam logic [4:0] KIND_NUMBER  = 5'd0;
  localparam logic [4:0] KIND_FLOAT   = 5'd1;
  localparam logic [4:0] KIND_IDENT   = 5'd2;
  localparam logic [4:0] KIND_LOG     = 5'd3;
  localparam logic [4:0] KIND_WHILE   = 5'd4;
  localparam logic [4:0] KIND_FOR     = 5'd5;
  localparam logic [4:0] KIND_IF      = 5'd6;
  localparam logic [4:0] KIND_ELSE    = 5'd7;
  localparam logic [4:0] KIND_ELIF    = 5'd8;
  localparam logic [4:0] KIND_BOOL    = 5'd9;
  localparam logic [4:0] KIND_STRING  = 5'd10;
  localparam logic [4:0] KIND_PLUS    = 5'd11;
  localparam logic [4:0] KIND_INC     = 5'd12;
  localparam logic [4:0] KIND_MINUS   = 5'd13;
  localparam logic [4:0] KIND_DEC     = 5'd14;
  localparam logic [4:0] KIND_STAR    = 5'd15;
  localparam logic [4:0] KIND_SLASH   = 5'd16;
  localparam logic [4:0] KIND_LPAREN  = 5'd17;
  localparam logic [4:0] KIND_RPAREN  = 5'd18;
  localparam logic [4:0] KIND_LBRACE  = 5'd19;
  localparam logic [4:0] KIND_RBRACE  = 5'd20;
  localparam logic [4:0] KIND_ASSIGN  = 5'd21;
  localparam logic [4:0] KIND_EQ      = 5'd22;
  localparam logic [4:0] KIND_LT      = 5'd23;
  localparam logic [4:0] KIND_LE      = 5'd24;
  localparam logic [4:0] KIND_GT      = 5'd25;
  localparam logic [4:0] KIND_GE      = 5'd26;
  localparam logic [4:0] KIND_SEMI    = 5'd27;
  localparam logic [4:0] KIND_ERROR   = 5'd28;

  // Error codes.
  localparam logic [1:0] ERR_NONE         = 2'd0;
  localparam logic [1:0] ERR_UNEXPECTED   = 2'd1;
  localparam logic [1:0] ERR_ESCAPE       = 2'd2;
  localparam logic [1:0] ERR_UNTERMINATED = 2'd3;

  typedef enum logic [3:0] {
    MODE_IDLE,
    MODE_NUM,
    MODE_NUM_DOT,
    MODE_WORD,
    MODE_STR,
    MODE_STR_ESC,
    MODE_PLUS,
    MODE_MINUS,
    MODE_EQ,
    MODE_LT,
    MODE_GT,
    MODE_SKIP
  } lex_mode_e;

  typedef struct packed {
    logic [4:0]         token_kind;
    logic [FIELD_W-1:0] token_start;
    logic [FIELD_W-1:0] token_length;
    logic [LINE_W-1:0]  line_count;
    logic [1:0]         error_code;
    logic               run_last;
  } res_t;

  // Up to two results caused by one byte, first in stream order.
  typedef struct packed {
    logic [1:0] count;
    res_t       first;
    res_t       second;
  } result_pair_t;

  // Keyword table.
  localparam int unsigned KW_COUNT   = 8;
  localparam int unsigned KW_MAX_LEN = 5;
  localparam int unsigned KW_LEN_W   = 3;

  localparam logic [7:0] KW_CHARS [KW_COUNT][KW_MAX_LEN] = '{
    '{"l", "o", "g", 8'h00, 8'h00},
    '{"w", "h", "i", "l", "e"},
    '{"f", "o", "r", 8'h00, 8'h00},
    '{"i", "f", 8'h00, 8'h00, 8'h00},
    '{"e", "l", "s", "e", 8'h00},
    '{"e", "l", "i", "f", 8'h00},
    '{"t", "r", "u", "e", 8'h00},
    '{"f", "a", "l", "s", "e"}
  };

  localparam logic [KW_LEN_W-1:0] KW_LEN [KW_COUNT] = '{
    3'd3, 3'd5, 3'd3, 3'd2, 3'd4, 3'd4, 3'd4, 3'd5
  };

  localparam logic [4:0] KW_KIND [KW_COUNT] = '{
    KIND_LOG, KIND_WHILE, KIND_FOR, KIND_IF, KIND_ELSE, KIND_ELIF, KIND_BOOL, KIND_BOOL
  };

  // Classifies a finished word. short_word is low when the word is longer than any keyword.
  function automatic logic [4:0] keyword_kind(input logic [KW_MAX_LEN-1:0][7:0] chars,
                                              input logic [KW_LEN_W-1:0] len,
                                              input logic short_word);
    logic [4:0] kind;
    logic       hit;
    kind = KIND_IDENT;
    for (int k = 0; k < KW_COUNT; k++) begin
      hit = short_word && (len == KW_LEN[k]);
      for (int i = 0; i < KW_MAX_LEN; i++) begin
        if ((i < int'(KW_LEN[k])) && (chars[i] != KW_CHARS[k][i])) begin
          hit = 1'b0;
        end
      end
      if (hit) begin
        kind = KW_KIND[k];
      end
    end
    return kind;
  endfunction

endpackage

// ===== rtl/stt_text_if.sv =====
// Request channel carrying source text bytes into the tokenizer.
`timescale 1ns / 1ps

interface stt_text_if;
  logic       valid;
  logic       ready;
  logic [7:0] text_byte;
  logic       end_of_text;

  modport source (output valid, output text_byte, output end_of_text, input ready);
  modport sink (input valid, input text_byte, input end_of_text, output ready);
endinterface

// ===== rtl/stt_token_if.sv =====
// Request channel carrying token results out of the tokenizer.
`timescale 1ns / 1ps

interface stt_token_if;
  logic        valid;
  logic        ready;
  logic [4:0]  token_kind;
  logic [15:0] token_start;
  logic [15:0] token_length;
  logic [15:0] line_count;
  logic [1:0]  error_code;
  logic        run_last;

  modport source (output valid, output token_kind, output token_start, output token_length,
                  output line_count, output error_code, output run_last, input ready);
  modport sink (input valid, input token_kind, input token_start, input token_length,
                input line_count, input error_code, input run_last, output ready);
endinterface

// ===== rtl/stt_lexer.sv =====
// Lexer state and the single-pass byte classification that yields up to two results.
`timescale 1ns / 1ps

module stt_lexer #(
  parameter int unsigned POSITION_BITS = stt_pkg::POSITION_BITS_DEF,
  parameter int unsigned KEYWORD_CHARS = stt_pkg::KEYWORD_CHARS_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  advance_i,
  input  logic [7:0]            text_byte_i,
  input  logic                  end_of_text_i,
  output stt_pkg::result_pair_t results_o
);
  import stt_pkg::*;

  localparam int unsigned IDX_W = $clog2(KEYWORD_CHARS);
  localparam logic [POSITION_BITS-1:0] POS_MAX  = {POSITION_BITS{1'b1}};
  localparam logic [POSITION_BITS-1:0] POS_ONE  = POSITION_BITS'(1);
  localparam logic [POSITION_BITS-1:0] KC_LIMIT = POSITION_BITS'(KEYWORD_CHARS);
  localparam logic [POSITION_BITS-1:0] KW_LIMIT = POSITION_BITS'(KW_MAX_LEN);
  localparam logic [LINE_W-1:0]        LINE_ONE = LINE_W'(1);
  localparam logic [LINE_W-1:0]        LINE_MAX = {LINE_W{1'b1}};
  localparam logic [FIELD_W-1:0]       LEN_ONE  = FIELD_W'(1);
  localparam logic [FIELD_W-1:0]       LEN_TWO  = FIELD_W'(2);

  localparam logic [7:0] CH_QUOTE      = 8'h22;
  localparam logic [7:0] CH_BACKSLASH  = 8'h5C;
  localparam logic [7:0] CH_SEMI       = 8'h3B;
  localparam logic [7:0] CH_DOT        = 8'h2E;
  localparam logic [7:0] CH_UNDERSCORE = 8'h5F;
  localparam logic [7:0] CH_PLUS       = 8'h2B;
  localparam logic [7:0] CH_MINUS      = 8'h2D;
  localparam logic [7:0] CH_EQUAL      = 8'h3D;
  localparam logic [7:0] CH_LESS       = 8'h3C;
  localparam logic [7:0] CH_GREATER    = 8'h3E;
  localparam logic [7:0] CH_STAR       = 8'h2A;
  localparam logic [7:0] CH_SLASH      = 8'h2F;
  localparam logic [7:0] CH_LPAREN     = 8'h28;
  localparam logic [7:0] CH_RPAREN     = 8'h29;
  localparam logic [7:0] CH_LBRACE     = 8'h7B;
  localparam logic [7:0] CH_RBRACE     = 8'h7D;

  typedef struct packed {
    logic valid;
    res_t res;
  } cand_t;

  function automatic logic is_digit(input logic [7:0] ch);
    return ch inside {["0":"9"]};
  endfunction

  function automatic logic is_alpha(input logic [7:0] ch);
    return ch inside {["a":"z"], ["A":"Z"]};
  endfunction

  function automatic logic is_space(input logic [7:0] ch);
    return ch inside {8'h20, [8'h09:8'h0D]};
  endfunction

  function automatic cand_t make_token(input logic [4:0] kind, input logic [FIELD_W-1:0] start,
                                       input logic [FIELD_W-1:0] len, input logic [1:0] err);
    cand_t t;
    t = '0;
    t.valid = 1'b1;
    t.res.token_kind = kind;
    t.res.token_start = start;
    t.res.token_length = len;
    t.res.error_code = err;
    return t;
  endfunction

  // Result for a token that is still open when a byte ends it.
  function automatic cand_t flush_token(input lex_mode_e mode, input logic [FIELD_W-1:0] start,
                                        input logic [FIELD_W-1:0] len, input logic [4:0] wkind);
    cand_t t;
    t = '0;
    case (mode)
      MODE_NUM:     t = make_token(KIND_NUMBER, start, len, ERR_NONE);
      MODE_NUM_DOT: t = make_token(KIND_FLOAT, start, len, ERR_NONE);
      MODE_WORD:    t = make_token(wkind, start, len, ERR_NONE);
      MODE_PLUS:    t = make_token(KIND_PLUS, start, LEN_ONE, ERR_NONE);
      MODE_MINUS:   t = make_token(KIND_MINUS, start, LEN_ONE, ERR_NONE);
      MODE_EQ:      t = make_token(KIND_ASSIGN, start, LEN_ONE, ERR_NONE);
      MODE_LT:      t = make_token(KIND_LT, start, LEN_ONE, ERR_NONE);
      MODE_GT:      t = make_token(KIND_GT, start, LEN_ONE, ERR_NONE);
      default:      t = '0;
    endcase
    return t;
  endfunction

  logic [7:0] ch;
  assign ch = text_byte_i;

  lex_mode_e                mode_q, mode_d, mode_n;
  logic [POSITION_BITS-1:0] start_q, start_d, start_n;
  logic [POSITION_BITS-1:0] span_q, span_d, span_n, span_inc;
  logic [POSITION_BITS-1:0] pos_q, pos_d;
  logic [LINE_W-1:0]        line_q, line_d, line_n;
  logic                     too_long_q, too_long_d, too_long_n;
  logic [7:0]               word_q [KEYWORD_CHARS];
  logic                     wr_en;
  logic [IDX_W-1:0]         wr_idx;
  logic                     opens;
  logic                     fall;
  logic                     idle_go;

  logic [KW_MAX_LEN-1:0][7:0] chars_now, chars_end;
  logic [4:0]                 kind_now, kind_end;
  cand_t                      cand_a, cand_b, cand_e;
  logic [1:0]                 total;

  // A byte that does not extend the open token closes it and is then lexed from idle.
  always_comb begin
    fall = 1'b0;
    idle_go = 1'b0;
    case (mode_q)
      MODE_IDLE:    idle_go = 1'b1;
      MODE_NUM:     fall = !(is_digit(ch) || (ch == CH_DOT));
      MODE_NUM_DOT: fall = !is_digit(ch);
      MODE_WORD:    fall = !(is_alpha(ch) || is_digit(ch) || (ch == CH_UNDERSCORE));
      MODE_PLUS:    fall = (ch != CH_PLUS);
      MODE_MINUS:   fall = (ch != CH_MINUS);
      MODE_EQ, MODE_LT, MODE_GT: fall = (ch != CH_EQUAL);
      default:      fall = 1'b0;
    endcase
    if (fall) begin
      idle_go = 1'b1;
    end
  end

  // Next state.
  always_comb begin
    span_inc = (span_q == POS_MAX) ? span_q : span_q + POS_ONE;
    mode_n = mode_q;
    start_n = start_q;
    span_n = span_q;
    too_long_n = too_long_q;
    line_n = line_q;
    wr_en = 1'b0;
    wr_idx = '0;
    opens = 1'b0;
    case (mode_q)
      MODE_NUM, MODE_NUM_DOT: begin
        if (!fall) begin
          span_n = span_inc;
          if (ch == CH_DOT) begin
            mode_n = MODE_NUM_DOT;
          end
        end
      end
      MODE_WORD: begin
        if (!fall) begin
          if (span_q < KC_LIMIT) begin
            wr_en = 1'b1;
            wr_idx = span_q[IDX_W-1:0];
          end else begin
            too_long_n = 1'b1;
          end
          span_n = span_inc;
        end
      end
      MODE_STR: begin
        span_n = span_inc;
        if (ch == CH_QUOTE) begin
          mode_n = MODE_IDLE;
        end else if (ch == CH_BACKSLASH) begin
          mode_n = MODE_STR_ESC;
        end
      end
      MODE_STR_ESC: begin
        span_n = span_inc;
        mode_n = ((ch == CH_QUOTE) || (ch == CH_BACKSLASH)) ? MODE_STR : MODE_SKIP;
      end
      MODE_PLUS, MODE_MINUS, MODE_EQ, MODE_LT, MODE_GT: mode_n = MODE_IDLE;
      default: ;
    endcase
    if (fall) begin
      mode_n = MODE_IDLE;
    end
    if (idle_go && !is_space(ch)) begin
      if (is_digit(ch)) begin
        mode_n = MODE_NUM;
        opens = 1'b1;
      end else if (is_alpha(ch)) begin
        mode_n = MODE_WORD;
        opens = 1'b1;
        too_long_n = 1'b0;
        wr_en = 1'b1;
        wr_idx = '0;
      end else begin
        case (ch)
          CH_QUOTE: begin
            mode_n = MODE_STR;
            opens = 1'b1;
          end
          CH_PLUS: begin
            mode_n = MODE_PLUS;
            opens = 1'b1;
          end
          CH_MINUS: begin
            mode_n = MODE_MINUS;
            opens = 1'b1;
          end
          CH_EQUAL: begin
            mode_n = MODE_EQ;
            opens = 1'b1;
          end
          CH_LESS: begin
            mode_n = MODE_LT;
            opens = 1'b1;
          end
          CH_GREATER: begin
            mode_n = MODE_GT;
            opens = 1'b1;
          end
          CH_STAR, CH_SLASH, CH_LPAREN, CH_RPAREN, CH_LBRACE, CH_RBRACE: ;
          CH_SEMI: begin
            if (line_q != LINE_MAX) begin
              line_n = line_q + LINE_ONE;
            end
          end
          default: mode_n = MODE_SKIP;
        endcase
      end
      if (opens) begin
        start_n = pos_q;
        span_n = POS_ONE;
      end
    end

    // The last byte of the text returns everything to its reset value.
    if (end_of_text_i) begin
      mode_d = MODE_IDLE;
      start_d = '0;
      span_d = '0;
      pos_d = '0;
      line_d = LINE_ONE;
      too_long_d = 1'b0;
    end else begin
      mode_d = mode_n;
      start_d = start_n;
      span_d = span_n;
      pos_d = (pos_q == POS_MAX) ? pos_q : pos_q + POS_ONE;
      line_d = line_n;
      too_long_d = too_long_n;
    end
  end

  // Keyword lookup on the word as it stands now and as it stands after this byte.
  always_comb begin
    for (int i = 0; i < KW_MAX_LEN; i++) begin
      chars_now[i] = word_q[i];
      chars_end[i] = (wr_en && (wr_idx == IDX_W'(i))) ? ch : word_q[i];
    end
    kind_now = keyword_kind(chars_now, span_q[KW_LEN_W-1:0],
                            !too_long_q && (span_q <= KW_LIMIT));
    kind_end = keyword_kind(chars_end, span_n[KW_LEN_W-1:0],
                            !too_long_n && (span_n <= KW_LIMIT));
  end

  // Outputs: results from the open token, from the byte itself, and from the end of text.
  always_comb begin
    cand_a = '0;
    cand_b = '0;
    cand_e = '0;
    case (mode_q)
      MODE_STR: begin
        if (ch == CH_QUOTE) begin
          cand_a = make_token(KIND_STRING, FIELD_W'(start_q), FIELD_W'(span_inc), ERR_NONE);
        end
      end
      MODE_STR_ESC: begin
        if ((ch != CH_QUOTE) && (ch != CH_BACKSLASH)) begin
          cand_a = make_token(KIND_ERROR, FIELD_W'(pos_q), LEN_ONE, ERR_ESCAPE);
        end
      end
      MODE_PLUS: begin
        if (!fall) cand_a = make_token(KIND_INC, FIELD_W'(start_q), LEN_TWO, ERR_NONE);
      end
      MODE_MINUS: begin
        if (!fall) cand_a = make_token(KIND_DEC, FIELD_W'(start_q), LEN_TWO, ERR_NONE);
      end
      MODE_EQ: begin
        if (!fall) cand_a = make_token(KIND_EQ, FIELD_W'(start_q), LEN_TWO, ERR_NONE);
      end
      MODE_LT: begin
        if (!fall) cand_a = make_token(KIND_LE, FIELD_W'(start_q), LEN_TWO, ERR_NONE);
      end
      MODE_GT: begin
        if (!fall) cand_a = make_token(KIND_GE, FIELD_W'(start_q), LEN_TWO, ERR_NONE);
      end
      default: ;
    endcase
    if (fall) begin
      cand_a = flush_token(mode_q, FIELD_W'(start_q), FIELD_W'(span_q), kind_now);
    end

    if (idle_go) begin
      case (ch)
        CH_STAR:   cand_b = make_token(KIND_STAR, FIELD_W'(pos_q), LEN_ONE, ERR_NONE);
        CH_SLASH:  cand_b = make_token(KIND_SLASH, FIELD_W'(pos_q), LEN_ONE, ERR_NONE);
        CH_LPAREN: cand_b = make_token(KIND_LPAREN, FIELD_W'(pos_q), LEN_ONE, ERR_NONE);
        CH_RPAREN: cand_b = make_token(KIND_RPAREN, FIELD_W'(pos_q), LEN_ONE, ERR_NONE);
        CH_LBRACE: cand_b = make_token(KIND_LBRACE, FIELD_W'(pos_q), LEN_ONE, ERR_NONE);
        CH_RBRACE: cand_b = make_token(KIND_RBRACE, FIELD_W'(pos_q), LEN_ONE, ERR_NONE);
        CH_SEMI:   cand_b = make_token(KIND_SEMI, FIELD_W'(pos_q), LEN_ONE, ERR_NONE);
        CH_QUOTE, CH_PLUS, CH_MINUS, CH_EQUAL, CH_LESS, CH_GREATER: ;
        default: begin
          if (!is_space(ch) && !is_digit(ch) && !is_alpha(ch)) begin
            cand_b = make_token(KIND_ERROR, FIELD_W'(pos_q), LEN_ONE, ERR_UNEXPECTED);
          end
        end
      endcase
    end

    if (end_of_text_i) begin
      if ((mode_n == MODE_STR) || (mode_n == MODE_STR_ESC)) begin
        cand_e = make_token(KIND_ERROR, FIELD_W'(start_n), FIELD_W'(span_n), ERR_UNTERMINATED);
      end else begin
        cand_e = flush_token(mode_n, FIELD_W'(start_n), FIELD_W'(span_n), kind_end);
      end
    end

    total = 2'({1'b0, cand_a.valid} + {1'b0, cand_b.valid} + {1'b0, cand_e.valid});
    results_o.count = (total > 2'd2) ? 2'd2 : total;
    results_o.first = cand_a.valid ? cand_a.res : (cand_b.valid ? cand_b.res : cand_e.res);
    results_o.second = cand_a.valid ? (cand_b.valid ? cand_b.res : cand_e.res) : cand_e.res;
    // Every result of one byte carries the line count from before the byte.
    results_o.first.line_count = line_q;
    results_o.second.line_count = line_q;
    results_o.first.run_last = (results_o.count == 2'd1);
    results_o.second.run_last = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= MODE_IDLE;
      start_q <= '0;
      span_q <= '0;
      pos_q <= '0;
      line_q <= LINE_ONE;
      too_long_q <= 1'b0;
    end else if (advance_i) begin
      mode_q <= mode_d;
      start_q <= start_d;
      span_q <= span_d;
      pos_q <= pos_d;
      line_q <= line_d;
      too_long_q <= too_long_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance_i && wr_en) begin
      word_q[wr_idx] <= ch;
    end
  end

  a_text_end_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance_i && end_of_text_i |=> (mode_q == MODE_IDLE) && (pos_q == '0) && (line_q == LINE_ONE))
    else $error("lexer state not cleared after the last byte of the text");

  a_skip_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (mode_q == MODE_SKIP) |-> (results_o.count == 2'd0))
    else $error("result produced while skipping after an error");

  a_line_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    line_q != '0)
    else $error("line counter reached zero");

endmodule

// ===== rtl/stt_result_queue.sv =====
// Two-entry result register that presents token results one per request.
`timescale 1ns / 1ps

module stt_result_queue (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  push_i,
  input  stt_pkg::result_pair_t results_i,
  output logic                  room_o,
  stt_token_if.source           token_o
);
  import stt_pkg::*;

  logic [1:0] cnt_q, cnt_d;
  res_t       head_q, head_d;
  res_t       tail_q, tail_d;
  logic       pop;

  assign pop = token_o.valid && token_o.ready;
  // A new pair is loaded only when the queue is empty by the end of this cycle.
  assign room_o = (cnt_q == 2'd0) || ((cnt_q == 2'd1) && pop);

  always_comb begin
    cnt_d = cnt_q;
    head_d = head_q;
    tail_d = tail_q;
    if (push_i) begin
      head_d = results_i.first;
      tail_d = results_i.second;
      cnt_d = results_i.count;
    end else if (pop) begin
      head_d = tail_q;
      cnt_d = cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= 2'd0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    head_q <= head_d;
    tail_q <= tail_d;
  end

  assign token_o.valid = (cnt_q != 2'd0);
  assign token_o.token_kind = head_q.token_kind;
  assign token_o.token_start = head_q.token_start;
  assign token_o.token_length = head_q.token_length;
  assign token_o.line_count = head_q.line_count;
  assign token_o.error_code = head_q.error_code;
  assign token_o.run_last = head_q.run_last;

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= 2'd2)
    else $error("result queue holds more than two entries");

  a_pair_kept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i && (results_i.count == 2'd2) |=> (cnt_q == 2'd2) && !head_q.run_last)
    else $error("pair of results not held in order");

endmodule

// ===== rtl/source_text_tokenizer.sv =====
// Top level of the streaming source text tokenizer.
`timescale 1ns / 1ps

// Streaming tokenizer: source text enters one byte per request on text_i, with
// end_of_text set on the final byte, and tokens leave on token_o as kind, start
// offset, span length, line number and error code. A token that the next byte
// could still extend is reported when that byte arrives, or at the end of the
// text, so a byte causes zero, one or two results; run_last marks the final
// result of each byte. The block takes one byte per cycle as long as each byte
// causes at most one result and the sink keeps up: a byte sits in the input
// register, is lexed in a single pass against the lexer state, and its results
// load the two-entry result register that drives token_o. A byte that causes
// two results holds up the next byte, since the next byte is lexed only once the
// result register is empty by the end of the cycle. text_i.ready follows
// token_o.ready within the same cycle. After an error every byte up to the end
// of the text is dropped, and after the final byte all counters, including the
// line number that each ';' advances, return to their reset values. No clearing
// pass is needed after reset.

module source_text_tokenizer #(
  parameter int unsigned POSITION_BITS = stt_pkg::POSITION_BITS_DEF,
  parameter int unsigned KEYWORD_CHARS = stt_pkg::KEYWORD_CHARS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  stt_text_if.sink    text_i,
  stt_token_if.source token_o
);
  import stt_pkg::*;

  logic         in_valid_q, in_valid_d;
  logic [7:0]   byte_q;
  logic         last_q;
  logic         advance;
  logic         room;
  result_pair_t results;

  // The held byte is lexed as soon as the result register can take its results.
  assign advance = in_valid_q && room;
  assign text_i.ready = !in_valid_q || advance;

  always_comb begin
    if (text_i.valid && text_i.ready) begin
      in_valid_d = 1'b1;
    end else if (advance) begin
      in_valid_d = 1'b0;
    end else begin
      in_valid_d = in_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else begin
      in_valid_q <= in_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (text_i.valid && text_i.ready) begin
      byte_q <= text_i.text_byte;
      last_q <= text_i.end_of_text;
    end
  end

  stt_lexer #(
    .POSITION_BITS(POSITION_BITS),
    .KEYWORD_CHARS(KEYWORD_CHARS)
  ) u_lexer (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .advance_i     (advance),
    .text_byte_i   (byte_q),
    .end_of_text_i (last_q),
    .results_o     (results)
  );

  stt_result_queue u_queue (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .push_i    (advance),
    .results_i (results),
    .room_o    (room),
    .token_o   (token_o)
  );

endmodule

// ===== tb/source_text_tokenizer_test.sv =====
// Self-checking testbench for the source text tokenizer with its own token predictor.
`timescale 1ns / 1ps

module source_text_tokenizer_test;
  import stt_pkg::*;

  localparam int unsigned RANDOM_BYTES = 720;
  localparam int unsigned DRAIN_CYCLES = 8;
  localparam int unsigned STALL_LIMIT  = 2000;

  logic clk_i = 1'b0;
  logic rst_ni;

  stt_text_if  text_bus ();
  stt_token_if token_bus ();

  source_text_tokenizer i_dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .text_i  (text_bus),
    .token_o (token_bus)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Lexer state as the predictor sees it.
  lex_mode_e   lx_mode;
  logic [15:0] lx_start;
  logic [15:0] lx_span;
  logic [15:0] lx_pos;
  logic [15:0] lx_line;
  logic [7:0]  lx_word [5];
  logic        lx_long;

  res_t tokens_due [$];
  res_t byte_tokens [$];
  res_t due_token;

  logic [7:0] text_q [$];

  int unsigned src_idle_pct   = 0;
  int unsigned sink_stall_pct = 0;
  int unsigned sent_bytes     = 0;
  int unsigned fail_count     = 0;
  int unsigned quiet_cycles   = 0;

  string      keyword_text [8]  = '{"log", "while", "for", "if", "else", "elif", "true", "false"};
  logic [4:0] keyword_token [8] = '{KIND_LOG, KIND_WHILE, KIND_FOR, KIND_IF, KIND_ELSE,
                                    KIND_ELIF, KIND_BOOL, KIND_BOOL};
  string WORD_CHARS = "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ0123456789_";
  string SINGLE_OPS = "+-*/(){}=<>";
  string PAIR_OPS   = "++--==<=>=";

  // ---------------------------------------------------------------- predictor

  function automatic logic [15:0] bump(input logic [15:0] v);
    return (v == 16'hFFFF) ? v : v + 16'd1;
  endfunction

  function automatic bit is_digit(input logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic bit is_alpha(input logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
  endfunction

  function automatic void reset_lexer();
    lx_mode  = MODE_IDLE;
    lx_start = '0;
    lx_span  = '0;
    lx_pos   = '0;
    lx_line  = 16'd1;
    lx_long  = 1'b0;
    foreach (lx_word[i]) lx_word[i] = '0;
  endfunction

  // A byte yields at most two tokens; anything beyond that is dropped.
  function automatic void push_token(input logic [4:0] kind, input logic [15:0] start_at,
                                     input logic [15:0] span, input logic [1:0] err);
    res_t t;
    if (byte_tokens.size() >= 2) return;
    t.token_kind   = kind;
    t.token_start  = start_at;
    t.token_length = span;
    t.line_count   = lx_line;
    t.error_code   = err;
    t.run_last     = 1'b0;
    byte_tokens.insert(byte_tokens.size(), t);
  endfunction

  function automatic void start_token(input lex_mode_e mode, input logic [15:0] pos);
    lx_mode  = mode;
    lx_start = pos;
    lx_span  = 16'd1;
  endfunction

  // Emits whatever token is still open in the current mode.
  function automatic void flush_token();
    logic [4:0] kind;
    bit         hit;
    case (lx_mode)
      MODE_NUM:     push_token(KIND_NUMBER, lx_start, lx_span, ERR_NONE);
      MODE_NUM_DOT: push_token(KIND_FLOAT, lx_start, lx_span, ERR_NONE);
      MODE_WORD: begin
        kind = KIND_IDENT;
        // Only short words can be keywords, and only on an exact match.
        if (!lx_long && lx_span <= 16'd5) begin
          for (int k = 0; k < 8; k++) begin
            hit = (keyword_text[k].len() == int'(lx_span));
            for (int i = 0; i < int'(lx_span) && hit; i++) begin
              hit = (keyword_text[k][i] == lx_word[i]);
            end
            if (hit) kind = keyword_token[k];
          end
        end
        push_token(kind, lx_start, lx_span, ERR_NONE);
      end
      MODE_PLUS:  push_token(KIND_PLUS, lx_start, 16'd1, ERR_NONE);
      MODE_MINUS: push_token(KIND_MINUS, lx_start, 16'd1, ERR_NONE);
      MODE_EQ:    push_token(KIND_ASSIGN, lx_start, 16'd1, ERR_NONE);
      MODE_LT:    push_token(KIND_LT, lx_start, 16'd1, ERR_NONE);
      MODE_GT:    push_token(KIND_GT, lx_start, 16'd1, ERR_NONE);
      default: ;
    endcase
  endfunction

  // Handles a byte that arrives with no token open.
  function automatic void open_token(input logic [7:0] c, input logic [15:0] pos);
    if (c == " " || (c >= 8'd9 && c <= 8'd13)) return;
    if (is_digit(c)) begin
      start_token(MODE_NUM, pos);
      return;
    end
    if (is_alpha(c)) begin
      start_token(MODE_WORD, pos);
      lx_long    = 1'b0;
      lx_word[0] = c;
      return;
    end
    case (c)
      "\"": start_token(MODE_STR, pos);
      "+":  start_token(MODE_PLUS, pos);
      "-":  start_token(MODE_MINUS, pos);
      "=":  start_token(MODE_EQ, pos);
      "<":  start_token(MODE_LT, pos);
      ">":  start_token(MODE_GT, pos);
      "*":  push_token(KIND_STAR, pos, 16'd1, ERR_NONE);
      "/":  push_token(KIND_SLASH, pos, 16'd1, ERR_NONE);
      "(":  push_token(KIND_LPAREN, pos, 16'd1, ERR_NONE);
      ")":  push_token(KIND_RPAREN, pos, 16'd1, ERR_NONE);
      "{":  push_token(KIND_LBRACE, pos, 16'd1, ERR_NONE);
      "}":  push_token(KIND_RBRACE, pos, 16'd1, ERR_NONE);
      ";": begin
        // The semicolon carries the old line number; the count moves on after it.
        push_token(KIND_SEMI, pos, 16'd1, ERR_NONE);
        if (lx_line != 16'hFFFF) lx_line = lx_line + 16'd1;
      end
      default: begin
        push_token(KIND_ERROR, pos, 16'd1, ERR_UNEXPECTED);
        lx_mode = MODE_SKIP;
      end
    endcase
  endfunction

  function automatic void lex_byte(input logic [7:0] c, input logic [15:0] pos);
    case (lx_mode)
      MODE_SKIP: return;
      MODE_NUM, MODE_NUM_DOT: begin
        // A second dot ends the number and then counts as an unexpected byte.
        if (is_digit(c) || (c == "." && lx_mode == MODE_NUM)) begin
          lx_span = bump(lx_span);
          if (c == ".") lx_mode = MODE_NUM_DOT;
          return;
        end
      end
      MODE_WORD: begin
        if (is_alpha(c) || is_digit(c) || c == "_") begin
          if (lx_span < 16'd5) lx_word[lx_span[2:0]] = c;
          else lx_long = 1'b1;
          lx_span = bump(lx_span);
          return;
        end
      end
      MODE_STR: begin
        lx_span = bump(lx_span);
        if (c == "\"") begin
          push_token(KIND_STRING, lx_start, lx_span, ERR_NONE);
          lx_mode = MODE_IDLE;
        end else if (c == "\\") begin
          lx_mode = MODE_STR_ESC;
        end
        return;
      end
      MODE_STR_ESC: begin
        lx_span = bump(lx_span);
        if (c == "\"" || c == "\\") begin
          lx_mode = MODE_STR;
        end else begin
          push_token(KIND_ERROR, pos, 16'd1, ERR_ESCAPE);
          lx_mode = MODE_SKIP;
        end
        return;
      end
      MODE_PLUS: begin
        if (c == "+") begin
          push_token(KIND_INC, lx_start, 16'd2, ERR_NONE);
          lx_mode = MODE_IDLE;
          return;
        end
      end
      MODE_MINUS: begin
        if (c == "-") begin
          push_token(KIND_DEC, lx_start, 16'd2, ERR_NONE);
          lx_mode = MODE_IDLE;
          return;
        end
      end
      MODE_EQ: begin
        if (c == "=") begin
          push_token(KIND_EQ, lx_start, 16'd2, ERR_NONE);
          lx_mode = MODE_IDLE;
          return;
        end
      end
      MODE_LT: begin
        if (c == "=") begin
          push_token(KIND_LE, lx_start, 16'd2, ERR_NONE);
          lx_mode = MODE_IDLE;
          return;
        end
      end
      MODE_GT: begin
        if (c == "=") begin
          push_token(KIND_GE, lx_start, 16'd2, ERR_NONE);
          lx_mode = MODE_IDLE;
          return;
        end
      end
      default: begin
        open_token(c, pos);
        return;
      end
    endcase
    // The byte does not extend the open token: close it and start over.
    flush_token();
    lx_mode = MODE_IDLE;
    open_token(c, pos);
  endfunction

  // Works out the tokens that one accepted byte causes and queues them.
  function automatic void predict_tokens(input logic [7:0] c, input logic eot);
    byte_tokens.delete();
    lex_byte(c, lx_pos);
    lx_pos = bump(lx_pos);
    if (eot) begin
      if (lx_mode == MODE_STR || lx_mode == MODE_STR_ESC) begin
        push_token(KIND_ERROR, lx_start, lx_span, ERR_UNTERMINATED);
      end else begin
        flush_token();
      end
      reset_lexer();
    end
    if (byte_tokens.size() > 0) begin
      byte_tokens[byte_tokens.size() - 1].run_last = 1'b1;
    end
    foreach (byte_tokens[i]) tokens_due.insert(tokens_due.size(), byte_tokens[i]);
  endfunction

  // ---------------------------------------------------------------- checking

  function automatic void check_field(input string field, input logic [15:0] want,
                                      input logic [15:0] got);
    if (want !== got) begin
      fail_count++;
      $display("%0t: %s mismatch, expected %0d actual %0d", $time, field, want, got);
    end
  endfunction

  always @(negedge clk_i) begin
    token_bus.ready = ($urandom_range(99) >= sink_stall_pct);
  end

  // Compares every accepted token with the oldest expectation, and stops the run
  // when neither channel has moved a request for too long.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (token_bus.valid && token_bus.ready) begin
        if (tokens_due.size() == 0) begin
          fail_count++;
          $display("%0t: token mismatch, expected none actual kind %0d start %0d",
                   $time, token_bus.token_kind, token_bus.token_start);
        end else begin
          due_token = tokens_due.pop_front();
          check_field("token_kind", 16'(due_token.token_kind), 16'(token_bus.token_kind));
          check_field("token_start", due_token.token_start, token_bus.token_start);
          check_field("token_length", due_token.token_length, token_bus.token_length);
          check_field("line_count", due_token.line_count, token_bus.line_count);
          check_field("error_code", 16'(due_token.error_code), 16'(token_bus.error_code));
          check_field("run_last", 16'(due_token.run_last), 16'(token_bus.run_last));
        end
      end
      if ((text_bus.valid && text_bus.ready) || (token_bus.valid && token_bus.ready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
        if (quiet_cycles >= STALL_LIMIT) begin
          $display("source_text_tokenizer_test failed");
          $finish;
        end
      end
    end
  end

  // ---------------------------------------------------------------- stimulus

  task automatic send_byte(input logic [7:0] c, input logic eot);
    @(negedge clk_i);
    while ($urandom_range(99) < src_idle_pct) begin
      text_bus.valid = 1'b0;
      @(negedge clk_i);
    end
    text_bus.valid       = 1'b1;
    text_bus.text_byte   = c;
    text_bus.end_of_text = eot;
    @(posedge clk_i);
    while (!text_bus.ready) @(posedge clk_i);
    sent_bytes++;
    predict_tokens(c, eot);
  endtask

  task automatic send_text(input string s);
    int n;
    n = s.len();
    for (int i = 0; i < n; i++) send_byte(s[i], i == n - 1);
  endtask

  // Holds the sender back until every expected token has come out, then lets
  // the pipeline settle.
  task automatic wait_idle();
    @(negedge clk_i);
    text_bus.valid = 1'b0;
    while (tokens_due.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  function automatic void add_char(input logic [7:0] c);
    text_q.insert(text_q.size(), c);
  endfunction

  // Builds one random text: mostly well-formed tokens with random content,
  // with some noise bytes and broken strings mixed in.
  task automatic compose_text();
    int         n_tok;
    int         pick;
    int         n;
    string      w;
    logic [7:0] ch;
    bit         ended;
    text_q.delete();
    ended = 1'b0;
    n_tok = $urandom_range(12, 1);
    for (int t = 0; t < n_tok && !ended; t++) begin
      pick = $urandom_range(99);
      if (pick < 15) begin
        repeat ($urandom_range(5, 1)) add_char(8'($urandom_range(9)) + "0");
        if ($urandom_range(2) == 0) begin
          add_char(".");
          repeat ($urandom_range(3)) add_char(8'($urandom_range(9)) + "0");
          if ($urandom_range(9) == 0) add_char(".");
        end
      end else if (pick < 40) begin
        if ($urandom_range(1) == 1) begin
          // Keywords, sometimes cut short or run on into a longer word.
          w = keyword_text[$urandom_range(7)];
          n = w.len();
          if ($urandom_range(3) == 0) n = n - 1;
          for (int i = 0; i < n; i++) add_char(w[i]);
          if ($urandom_range(3) == 0) begin
            repeat ($urandom_range(3, 1)) add_char(WORD_CHARS[$urandom_range(62)]);
          end
        end else begin
          add_char(WORD_CHARS[$urandom_range(51)]);
          repeat ($urandom_range(8)) add_char(WORD_CHARS[$urandom_range(62)]);
        end
      end else if (pick < 50) begin
        add_char("\"");
        repeat ($urandom_range(6)) begin
          case ($urandom_range(3))
            0: begin
              add_char("\\");
              add_char("\\");
            end
            1: begin
              add_char("\\");
              add_char("\"");
            end
            default: begin
              ch = 8'($urandom_range(255));
              if (ch == "\"" || ch == "\\") ch = "a";
              add_char(ch);
            end
          endcase
        end
        add_char("\"");
      end else if (pick < 75) begin
        if ($urandom_range(2) == 0) begin
          n = 2 * $urandom_range(4);
          add_char(PAIR_OPS[n]);
          add_char(PAIR_OPS[n + 1]);
        end else begin
          add_char(SINGLE_OPS[$urandom_range(10)]);
        end
      end else if (pick < 87) begin
        add_char(";");
      end else if (pick < 94) begin
        add_char(8'($urandom_range(255)));
      end else begin
        // Broken strings: a bad escape lets the text go on, the rest end it.
        add_char("\"");
        repeat ($urandom_range(3)) add_char(WORD_CHARS[$urandom_range(62)]);
        case ($urandom_range(3))
          0: begin
            ch = 8'($urandom_range(255));
            if (ch == "\"" || ch == "\\") ch = "n";
            add_char("\\");
            add_char(ch);
          end
          1: begin
            add_char("\\");
            ended = 1'b1;
          end
          2: begin
            add_char("\\");
            add_char("\"");
            ended = 1'b1;
          end
          default: ended = 1'b1;
        endcase
      end
      if (!ended) begin
        case ($urandom_range(5))
          0: add_char(" ");
          1: add_char(8'($urandom_range(13, 9)));
          default: ;
        endcase
      end
    end
  endtask

  // ---------------------------------------------------------------- tests

  // Every operator, two-byte forms included, ending on a pending one-byte
  // operator that only the end of the text can flush.
  task automatic test_operators();
    send_text("++--==<=>=*/(){};+-=<>");
    wait_idle();
  endtask

  // A second dot in a number, an unexpected byte at the low end of the byte
  // range with the bytes after it, up to one at the high end, ignored, a bad
  // escape, and two ways a string can be left open at the end of the text.
  task automatic test_error_recovery();
    send_text("1.2.");
    send_byte(8'h00, 1'b0);
    send_text("ab");
    send_byte(8'hFF, 1'b1);
    send_text("\"\\q");
    send_text("\"a\\");
    send_text("\"\\\"");
    wait_idle();
  endtask

  // Random texts under each mix of sender gaps and receiver stalls.
  task automatic test_random_traffic();
    int unsigned idle_tab [4]  = '{0, 65, 0, 30};
    int unsigned stall_tab [4] = '{0, 0, 65, 30};
    int unsigned goal;
    for (int p = 0; p < 4; p++) begin
      src_idle_pct   = idle_tab[p];
      sink_stall_pct = stall_tab[p];
      goal = sent_bytes + RANDOM_BYTES / 4;
      while (sent_bytes < goal) begin
        compose_text();
        foreach (text_q[i]) send_byte(text_q[i], i == text_q.size() - 1);
      end
      wait_idle();
    end
    src_idle_pct   = 0;
    sink_stall_pct = 0;
  endtask

  // Long tokens: words that run past the keyword buffer, keywords with one
  // letter too many, a long float, then a string left open at the end.
  task automatic test_long_tokens();
    send_text("whilefalse1 elsee falsee 12345678901234567890.123 \"ab");
    wait_idle();
  endtask

  initial begin
    text_bus.valid       = 1'b0;
    text_bus.text_byte   = '0;
    text_bus.end_of_text = 1'b0;
    rst_ni               = 1'b0;
    reset_lexer();
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    test_operators();
    test_error_recovery();
    test_random_traffic();
    test_long_tokens();

    wait_idle();
    if (fail_count == 0) begin
      $display("source_text_tokenizer_test passed");
    end else begin
      $display("source_text_tokenizer_test failed");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/stt_pkg.sv
rtl/stt_text_if.sv
rtl/stt_token_if.sv
rtl/stt_lexer.sv
rtl/stt_result_queue.sv
rtl/source_text_tokenizer.sv
tb/source_text_tokenizer_test.sv
